// File: rtl/jsu_pkg.sv
// jsu_pkg: shared types and constants of the json string unescaper
// no dependencies; used by jsu_front, jsu_queue, jsu_back and the top level

package jsu_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

  localparam logic [7:0] Backslash = 8'h5C;
  localparam logic [7:0] CharN = 8'h6E;
  localparam logic [7:0] CharT = 8'h74;
  localparam logic [7:0] CharR = 8'h72;
  localparam logic [7:0] CharB = 8'h62;
  localparam logic [7:0] CharF = 8'h66;
  localparam logic [7:0] CharU = 8'h75;

  localparam logic [15:0] SurrMask = 16'hFC00;
  localparam logic [15:0] SurrHigh = 16'hD800;
  localparam logic [15:0] SurrLow = 16'hDC00;
  localparam logic [CpWidth-1:0] SuppBase = 21'h010000;

  localparam logic [7:0] Lead2 = 8'hC0;
  localparam logic [7:0] Lead3 = 8'hE0;
  localparam logic [7:0] Lead4 = 8'hF0;
  localparam logic [7:0] ContMark = 8'h80;

  // one unit of work for the back end: a raw byte or a code point to encode
  typedef struct packed {
    logic               raw;
    logic [CpWidth-1:0] cp;
  } job_t;

endpackage

// File: rtl/jsu_front.sv
// jsu_front: escape parser, one source byte per beat, emits at most one job
// depends on jsu_pkg

module jsu_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    in_byte,
  input  logic          end_of_string,
  output logic          job_valid,
  output jsu_pkg::job_t job
);

  localparam logic [2:0] ModePlain = 3'd0;
  localparam logic [2:0] ModeEsc = 3'd1;
  localparam logic [2:0] ModeHex = 3'd2;
  localparam logic [2:0] ModeHeld = 3'd3;
  localparam logic [2:0] ModeHeldEsc = 3'd4;
  localparam logic [2:0] ModeLowHex = 3'd5;

  logic [2:0]  mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] hex_value, hex_value_next;
  logic        hex_stopped, hex_stopped_next;
  logic [9:0]  high_bits, high_bits_next;

  logic        digit_ok;
  logic [3:0]  digit;
  logic [15:0] hex_taken;
  logic        stop_taken;
  logic        hex_done;

  always_comb begin
    digit_ok = 1'b1;
    digit = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      digit = in_byte[3:0];
    end else if ((in_byte >= 8'h41 && in_byte <= 8'h46) ||
                 (in_byte >= 8'h61 && in_byte <= 8'h66)) begin
      digit = in_byte[3:0] + 4'd9;
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign hex_taken = (!hex_stopped && digit_ok) ? {hex_value[11:0], digit} : hex_value;
  assign stop_taken = hex_stopped | ~digit_ok;
  assign hex_done = (hex_count == 2'd3);

  always_comb begin
    mode_next = mode;
    hex_count_next = hex_count;
    hex_value_next = hex_value;
    hex_stopped_next = hex_stopped;
    high_bits_next = high_bits;
    job_valid = 1'b0;
    job.raw = 1'b1;
    job.cp = {{(jsu_pkg::CpWidth-8){1'b0}}, in_byte};

    unique case (mode)
      ModeEsc, ModeHeldEsc: begin
        mode_next = ModePlain;
        job_valid = 1'b1;
        unique case (in_byte)
          jsu_pkg::CharN: job.cp[7:0] = 8'h0A;
          jsu_pkg::CharT: job.cp[7:0] = 8'h09;
          jsu_pkg::CharR: job.cp[7:0] = 8'h0D;
          jsu_pkg::CharB: job.cp[7:0] = 8'h08;
          jsu_pkg::CharF: job.cp[7:0] = 8'h0C;
          jsu_pkg::CharU: begin
            job_valid = 1'b0;
            mode_next = (mode == ModeHeldEsc) ? ModeLowHex : ModeHex;
            hex_count_next = 2'd0;
            hex_value_next = 16'd0;
            hex_stopped_next = 1'b0;
          end
          default: ;
        endcase
      end
      ModeHex: begin
        hex_value_next = hex_taken;
        hex_stopped_next = stop_taken;
        if (hex_done) begin
          if ((hex_taken & jsu_pkg::SurrMask) == jsu_pkg::SurrHigh) begin
            high_bits_next = hex_taken[9:0];
            mode_next = ModeHeld;
          end else begin
            job_valid = 1'b1;
            job.raw = 1'b0;
            job.cp = {{(jsu_pkg::CpWidth-16){1'b0}}, hex_taken};
            mode_next = ModePlain;
          end
        end else begin
          hex_count_next = hex_count + 2'd1;
        end
      end
      ModeHeld: begin
        if (in_byte != jsu_pkg::Backslash) begin
          job_valid = 1'b1;
          mode_next = ModePlain;
        end else begin
          mode_next = ModeHeldEsc;
        end
      end
      ModeLowHex: begin
        hex_value_next = hex_taken;
        hex_stopped_next = stop_taken;
        if (hex_done) begin
          job_valid = 1'b1;
          job.raw = 1'b0;
          if ((hex_taken & jsu_pkg::SurrMask) == jsu_pkg::SurrLow) begin
            job.cp = {1'b0, high_bits, hex_taken[9:0]} + jsu_pkg::SuppBase;
          end else begin
            job.cp = {{(jsu_pkg::CpWidth-16){1'b0}}, hex_taken};
          end
          mode_next = ModePlain;
        end else begin
          hex_count_next = hex_count + 2'd1;
        end
      end
      default: begin
        if (in_byte != jsu_pkg::Backslash) begin
          job_valid = 1'b1;
        end else begin
          mode_next = ModeEsc;
        end
      end
    endcase

    if (end_of_string) begin
      mode_next = ModePlain;
      hex_count_next = 2'd0;
      hex_value_next = 16'd0;
      hex_stopped_next = 1'b0;
      high_bits_next = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModePlain;
      hex_count <= 2'd0;
      hex_value <= 16'd0;
      hex_stopped <= 1'b0;
      high_bits <= 10'd0;
    end else if (take) begin
      mode <= mode_next;
      hex_count <= hex_count_next;
      hex_value <= hex_value_next;
      hex_stopped <= hex_stopped_next;
      high_bits <= high_bits_next;
    end
  end

endmodule

// File: rtl/jsu_queue.sv
// jsu_queue: short register queue of jobs between front and back end
// depends on jsu_pkg

module jsu_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  jsu_pkg::job_t wr_data,
  input  logic          rd_en,
  output jsu_pkg::job_t rd_data,
  output logic          not_empty,
  output logic          full
);

  jsu_pkg::job_t slots [jsu_pkg::QueueDepth];
  logic [jsu_pkg::QueuePtrWidth-1:0] wr_ptr, rd_ptr;
  logic [jsu_pkg::QueuePtrWidth:0]   count;

  assign full = (count == (jsu_pkg::QueuePtrWidth+1)'(jsu_pkg::QueueDepth));
  assign not_empty = (count != '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/jsu_back.sv
// jsu_back: utf-8 encoder, one output beat per cycle from the queue head while pop keeps up
// depends on jsu_pkg

module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_ready,
  input  jsu_pkg::job_t job,
  output logic          job_done,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          run_last
);

  logic [1:0] idx;
  logic [1:0] len_m1;
  logic [1:0] remain;
  logic [7:0] byte_val;
  logic [5:0] cont_bits;
  logic       out_valid;
  logic       load;

  always_comb begin
    if (job.raw || job.cp < 21'h80) begin
      len_m1 = 2'd0;
    end else if (job.cp < 21'h800) begin
      len_m1 = 2'd1;
    end else if (job.cp < 21'h10000) begin
      len_m1 = 2'd2;
    end else begin
      len_m1 = 2'd3;
    end
  end

  assign remain = len_m1 - idx;

  always_comb begin
    unique case (remain)
      2'd0: cont_bits = job.cp[5:0];
      2'd1: cont_bits = job.cp[11:6];
      2'd2: cont_bits = job.cp[17:12];
      default: cont_bits = {3'd0, job.cp[20:18]};
    endcase
  end

  always_comb begin
    if (idx != 2'd0) begin
      byte_val = jsu_pkg::ContMark | {2'b00, cont_bits};
    end else begin
      unique case (len_m1)
        2'd0: byte_val = job.cp[7:0];
        2'd1: byte_val = jsu_pkg::Lead2 | {3'b000, job.cp[10:6]};
        2'd2: byte_val = jsu_pkg::Lead3 | {4'b0000, job.cp[15:12]};
        default: byte_val = jsu_pkg::Lead4 | {5'b00000, job.cp[20:18]};
      endcase
    end
  end

  assign load = job_ready && (!out_valid || pop);
  assign job_done = load && (idx == len_m1);
  assign empty = ~out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= byte_val;
      run_last <= (idx == len_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx <= job_done ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/json_string_unescape_utf8.sv
// json_string_unescape_utf8: top level of the json string unescaper
// depends on jsu_pkg, jsu_front, jsu_queue and jsu_back

// Escaped JSON string bytes go in one beat per cycle while full is low;
// unescaped UTF-8 bytes come out one beat per cycle while pop keeps up,
// with run_last marking the final byte caused by an input byte. The front
// parser takes a byte in every cycle in which the four-entry job queue has
// room; a byte that causes output leaves one job. The back end emits the
// bytes of a job in turn, so a \uXXXX escape gives 1 to 3 output bytes and
// a surrogate pair 4, and input stalls only once the queue has filled
// behind a run of multi-byte sequences or a stalled output side. The first
// output byte of an accepted byte passes through the job queue and the
// output register of the back end before it is on the result ports to pop.

module json_string_unescape_utf8 (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       run_last
);

  logic          take;
  logic          job_valid;
  jsu_pkg::job_t front_job;
  jsu_pkg::job_t head_job;
  logic          head_valid;
  logic          head_done;

  assign take = push & ~full;

  jsu_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .job_valid     (job_valid),
    .job           (front_job)
  );

  jsu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (take & job_valid),
    .wr_data   (front_job),
    .rd_en     (head_done),
    .rd_data   (head_job),
    .not_empty (head_valid),
    .full      (full)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_ready (head_valid),
    .job       (head_job),
    .job_done  (head_done),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

endmodule
